/* rtl/v3a_pkg.sv */
// Shared constants and operation codes for the three-component vector arithmetic unit.
package v3a_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_SCALE    = 4'd4,
    MODE_DIVSCALE = 4'd5,
    MODE_CROSS    = 4'd6,
    MODE_DOT      = 4'd7,
    MODE_LENSQ    = 4'd8,
    MODE_LEN      = 4'd9,
    MODE_LEN2DSQ  = 4'd10,
    MODE_LEN2D    = 4'd11,
    MODE_NORM     = 4'd12,
    MODE_DIST     = 4'd13,
    MODE_NEG      = 4'd14,
    MODE_CMP      = 4'd15
  } mode_t;

endpackage

/* rtl/v3a_mul_lane.sv */
// One multiplier lane: selects two operand pairs by mode and forms their product difference.
module v3a_mul_lane import v3a_pkg::*; #(
  parameter int WORD_W = WORD_BITS,
  parameter int LANE   = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  mode_t                     mode,
  input  logic signed [WORD_W-1:0]  a [3],
  input  logic signed [WORD_W-1:0]  b [3],
  input  logic signed [WORD_W-1:0]  s,
  output logic signed [2*WORD_W+2:0] c
);

  localparam int OW = WORD_W + 1;
  localparam int PW = 2 * OW;
  localparam int CW = PW + 1;
  localparam int J  = (LANE + 1) % 3;
  localparam int K  = (LANE + 2) % 3;

  logic signed [OW-1:0] x, y, u, v, dif;
  logic signed [PW-1:0] p_r, q_r;
  logic signed [CW-1:0] c_r;

  always_comb begin
    x   = '0;
    y   = '0;
    u   = '0;
    v   = '0;
    dif = OW'(a[LANE]) - OW'(b[LANE]);
    unique case (mode)
      MODE_MUL, MODE_DOT: begin
        x = OW'(a[LANE]);
        y = OW'(b[LANE]);
      end
      MODE_SCALE: begin
        x = OW'(a[LANE]);
        y = OW'(s);
      end
      MODE_CROSS: begin
        x = OW'(a[J]);
        y = OW'(b[K]);
        u = OW'(a[K]);
        v = OW'(b[J]);
      end
      MODE_LENSQ, MODE_LEN, MODE_NORM: begin
        x = OW'(a[LANE]);
        y = OW'(a[LANE]);
      end
      MODE_LEN2DSQ, MODE_LEN2D: begin
        if (LANE < 2) begin
          x = OW'(a[LANE]);
          y = OW'(a[LANE]);
        end
      end
      MODE_DIST: begin
        x = dif;
        y = dif;
      end
      MODE_CMP: begin
        x = OW'(a[LANE]);
        y = OW'(a[LANE]);
        u = OW'(b[LANE]);
        v = OW'(b[LANE]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= x * y;
      q_r <= u * v;
      c_r <= CW'(p_r) - CW'(q_r);
    end
  end

  assign c = c_r;

endmodule

/* rtl/v3a_merge.sv */
// Merging stage: sums the lane products and saturates lane and scalar results.
module v3a_merge #(
  parameter int WORD_W = 32,
  parameter int FRAC_W = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [2*WORD_W+2:0] c [3],
  output logic signed [WORD_W-1:0]   lane_res [3],
  output logic [2:0]                 lane_ov,
  output logic signed [WORD_W-1:0]   sc_res,
  output logic                       sc_ov,
  output logic                       longer,
  output logic                       shorter,
  output logic [2*WORD_W+5:0]        sumsq
);

  localparam int CW = 2 * WORD_W + 3;
  localparam int C1 = CW + 1;
  localparam int SW = CW + 2;
  localparam logic [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

  function automatic logic [WORD_W:0] fin_sat(input logic signed [SW-1:0] val_in);
    logic          neg;
    logic [SW-1:0] m;
    logic [SW-1:0] lim;
    logic [WORD_W-1:0] val;
    logic          ovf;
    neg = val_in[SW-1];
    m   = neg ? SW'(-val_in) : SW'(val_in);
    m   = m >> FRAC_W;
    lim = SW'(QMAX) + SW'(neg);
    ovf = m > lim;
    if (ovf) begin
      val = neg ? QMIN : QMAX;
    end else begin
      val = neg ? (~m[WORD_W-1:0] + 1'b1) : m[WORD_W-1:0];
    end
    return {ovf, val};
  endfunction

  logic [WORD_W:0] lf [3];
  logic [WORD_W:0] sf;

  logic signed [C1-1:0]     s01_r;
  logic signed [CW-1:0]     c2_r;
  logic signed [SW-1:0]     sum_r;
  logic signed [WORD_W-1:0] lres1_r [3];
  logic signed [WORD_W-1:0] lres2_r [3];
  logic signed [WORD_W-1:0] lres3_r [3];
  logic [2:0]               lov1_r, lov2_r, lov3_r;
  logic signed [WORD_W-1:0] sc_r;
  logic                     scov_r, longer_r, shorter_r;
  logic [SW:0]              sumsq_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lf[i] = fin_sat(SW'(c[i]));
    end
    sf = fin_sat(sum_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s01_r <= C1'(c[0]) + C1'(c[1]);
      c2_r  <= c[2];
      for (int i = 0; i < 3; i++) begin
        lres1_r[i] <= lf[i][WORD_W-1:0];
        lov1_r[i]  <= lf[i][WORD_W];
      end
      sum_r   <= SW'(s01_r) + SW'(c2_r);
      lres2_r <= lres1_r;
      lov2_r  <= lov1_r;
      sc_r      <= sf[WORD_W-1:0];
      scov_r    <= sf[WORD_W];
      longer_r  <= (sum_r > 0);
      shorter_r <= (sum_r < 0);
      sumsq_r   <= {1'b0, sum_r};
      lres3_r   <= lres2_r;
      lov3_r    <= lov2_r;
    end
  end

  assign lane_res = lres3_r;
  assign lane_ov  = lov3_r;
  assign sc_res   = sc_r;
  assign sc_ov    = scov_r;
  assign longer   = longer_r;
  assign shorter  = shorter_r;
  assign sumsq    = sumsq_r;

endmodule

/* rtl/v3a_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module v3a_sqrt #(
  parameter int ROOT_W = 35
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   x,
  output logic [ROOT_W-1:0]     root
);

  localparam int XW = 2 * ROOT_W;

  logic [ROOT_W+1:0] rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [XW-1:0]     xs_r    [ROOT_W];
  logic [ROOT_W+1:0] in_rem  [ROOT_W];
  logic [ROOT_W-1:0] in_root [ROOT_W];
  logic [XW-1:0]     in_xs   [ROOT_W];
  logic [ROOT_W+1:0] rem_t   [ROOT_W];
  logic [ROOT_W+1:0] trial   [ROOT_W];
  logic [ROOT_W-1:0] take;

  always_comb begin
    in_rem[0]  = '0;
    in_root[0] = '0;
    in_xs[0]   = x;
    for (int k = 1; k < ROOT_W; k++) begin
      in_rem[k]  = rem_r[k-1];
      in_root[k] = root_r[k-1];
      in_xs[k]   = xs_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      rem_t[k] = {in_rem[k][ROOT_W-1:0], in_xs[k][XW-1 -: 2]};
      trial[k] = {in_root[k], 2'b01};
      take[k]  = rem_t[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= take[k] ? (rem_t[k] - trial[k]) : rem_t[k];
        root_r[k] <= {in_root[k][ROOT_W-2:0], take[k]};
        xs_r[k]   <= in_xs[k] << 2;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

/* rtl/v3a_div_lane.sv */
// Pipelined fixed-point divider lane with sign handling and saturation.
module v3a_div_lane #(
  parameter int WORD_W = 32,
  parameter int FRAC_W = 16,
  parameter int DIV_W  = 35
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [WORD_W-1:0]        n_mag,
  input  logic                     n_neg,
  input  logic [DIV_W-1:0]         d_mag,
  input  logic                     d_neg,
  output logic signed [WORD_W-1:0] res,
  output logic                     ovf,
  output logic                     dz
);

  localparam int NW = WORD_W + FRAC_W;
  localparam logic [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic [DIV_W:0]   rem_r  [NW];
  logic [NW-1:0]    q_r    [NW];
  logic [NW-1:0]    ns_r   [NW];
  logic [DIV_W-1:0] d_r    [NW];
  logic [NW-1:0]    neg_r, nneg_r, nzero_r, dz_r;

  logic [DIV_W:0]   in_rem [NW];
  logic [NW-1:0]    in_q   [NW];
  logic [NW-1:0]    in_ns  [NW];
  logic [DIV_W-1:0] in_d   [NW];
  logic [NW-1:0]    in_neg, in_nneg, in_nzero, in_dz;
  logic [DIV_W:0]   rem_t  [NW];
  logic [NW-1:0]    ge;

  logic [NW-1:0]    qf, lim;
  logic signed [WORD_W-1:0] res_r;
  logic             ovf_r, dz_out_r;

  always_comb begin
    in_rem[0]   = '0;
    in_q[0]     = '0;
    in_ns[0]    = {n_mag, {FRAC_W{1'b0}}};
    in_d[0]     = d_mag;
    in_neg[0]   = n_neg ^ d_neg;
    in_nneg[0]  = n_neg;
    in_nzero[0] = (n_mag == '0);
    in_dz[0]    = (d_mag == '0);
    for (int k = 1; k < NW; k++) begin
      in_rem[k]   = rem_r[k-1];
      in_q[k]     = q_r[k-1];
      in_ns[k]    = ns_r[k-1];
      in_d[k]     = d_r[k-1];
      in_neg[k]   = neg_r[k-1];
      in_nneg[k]  = nneg_r[k-1];
      in_nzero[k] = nzero_r[k-1];
      in_dz[k]    = dz_r[k-1];
    end
    for (int k = 0; k < NW; k++) begin
      rem_t[k] = {in_rem[k][DIV_W-1:0], in_ns[k][NW-1]};
      ge[k]    = rem_t[k] >= {1'b0, in_d[k]};
    end
    qf  = q_r[NW-1];
    lim = NW'(QMAX) + NW'(neg_r[NW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k]   <= ge[k] ? (rem_t[k] - {1'b0, in_d[k]}) : rem_t[k];
        q_r[k]     <= {in_q[k][NW-2:0], ge[k]};
        ns_r[k]    <= in_ns[k] << 1;
        d_r[k]     <= in_d[k];
        neg_r[k]   <= in_neg[k];
        nneg_r[k]  <= in_nneg[k];
        nzero_r[k] <= in_nzero[k];
        dz_r[k]    <= in_dz[k];
      end
      if (dz_r[NW-1]) begin
        dz_out_r <= 1'b1;
        ovf_r    <= 1'b0;
        res_r    <= nzero_r[NW-1] ? '0 : (nneg_r[NW-1] ? QMIN : QMAX);
      end else if (qf > lim) begin
        dz_out_r <= 1'b0;
        ovf_r    <= 1'b1;
        res_r    <= neg_r[NW-1] ? QMIN : QMAX;
      end else begin
        dz_out_r <= 1'b0;
        ovf_r    <= 1'b0;
        res_r    <= neg_r[NW-1] ? (~qf[WORD_W-1:0] + 1'b1) : qf[WORD_W-1:0];
      end
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;
  assign dz  = dz_out_r;

endmodule

/* rtl/vector3_arith_unit.sv */
// Throughput: one transaction per cycle unless the output stalls; three multiplier lanes,
// a root stage per result bit and a divider stage per quotient bit all run as one pipeline.
// While a result is stalled at the output, the whole pipeline holds and the input stalls.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module vector3_arith_unit import v3a_pkg::*; #(
  parameter int WORD_W = WORD_BITS,
  parameter int FRAC_W = FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_mode,
  input  logic signed [WORD_W-1:0] in_ax,
  input  logic signed [WORD_W-1:0] in_ay,
  input  logic signed [WORD_W-1:0] in_az,
  input  logic signed [WORD_W-1:0] in_bx,
  input  logic signed [WORD_W-1:0] in_by_comp,
  input  logic signed [WORD_W-1:0] in_bz,
  input  logic signed [WORD_W-1:0] in_scalar_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_rx,
  output logic signed [WORD_W-1:0] out_ry,
  output logic signed [WORD_W-1:0] out_rz,
  output logic signed [WORD_W-1:0] out_scalar_out,
  output logic                     out_is_equal,
  output logic                     out_is_longer,
  output logic                     out_is_shorter,
  output logic                     out_overflow,
  output logic                     out_div_zero
);

  localparam int WP = WORD_W + 1;
  localparam int CW = 2 * WORD_W + 3;
  localparam int RW = WORD_W + 3;
  localparam int NW = WORD_W + FRAC_W;
  localparam int DA = 5 + RW;
  localparam int NV = 7 + RW + NW;
  localparam logic [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic adv;
  logic [NV-1:0] vld_r;

  mode_t                    e_mode_r;
  logic signed [WORD_W-1:0] e_a_r [3];
  logic signed [WORD_W-1:0] e_b_r [3];
  logic signed [WORD_W-1:0] e_s_r;

  logic signed [WORD_W:0]   ws [3];
  logic signed [WORD_W-1:0] sv [3];
  logic [2:0]               sv_ov;
  logic signed [WORD_W-1:0] dv [3];
  logic [WORD_W-1:0]        dmag0 [3];
  logic [WORD_W-1:0]        amag0 [3];
  logic                     eq0;

  mode_t                    mode_a_r  [DA];
  logic signed [WORD_W-1:0] a_a_r     [DA][3];
  logic [WORD_W-1:0]        amag_a_r  [DA][3];
  logic [WORD_W-1:0]        dmag_a_r  [DA][3];
  logic [2:0]               dneg_a_r  [DA];
  logic signed [WORD_W-1:0] simp_a_r  [DA][3];
  logic [DA-1:0]            simpov_a_r;
  logic [DA-1:0]            eq_a_r;

  logic signed [CW-1:0]     lane_c [3];
  logic signed [WORD_W-1:0] m_lres [3];
  logic [2:0]               m_lov;
  logic signed [WORD_W-1:0] m_sc;
  logic                     m_scov, m_lg, m_sh;
  logic [2*RW-1:0]          m_sumsq;
  logic [RW-1:0]            root;

  logic signed [WORD_W-1:0] lres_m_r [RW][3];
  logic [RW-1:0]            lov_m_r;
  logic signed [WORD_W-1:0] sc_m_r   [RW];
  logic [RW-1:0]            scov_m_r, lg_m_r, sh_m_r;

  mode_t                    md;
  logic signed [WORD_W-1:0] pre_r [3];
  logic signed [WORD_W-1:0] pre_so;
  logic                     pre_eq, pre_lg, pre_sh, pre_ov, use_div;
  logic [RW-1:0]            dd_mag [3];
  logic [2:0]               dd_neg;

  logic signed [WORD_W-1:0] div_res [3];
  logic [2:0]               div_ov, div_dz;

  logic signed [WORD_W-1:0] pre_r_b_r [NW+1][3];
  logic signed [WORD_W-1:0] pre_so_b_r [NW+1];
  logic [NW:0]              eq_b_r, lg_b_r, sh_b_r, ov_b_r, usediv_b_r;

  logic signed [WORD_W-1:0] rx_r, ry_r, rz_r, so_r;
  logic                     out_valid_r, eq_r, lg_r, sh_r, ovf_r, dz_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mode_r <= mode_t'(in_mode);
      e_a_r[0] <= in_ax;
      e_a_r[1] <= in_ay;
      e_a_r[2] <= in_az;
      e_b_r[0] <= in_bx;
      e_b_r[1] <= in_by_comp;
      e_b_r[2] <= in_bz;
      e_s_r    <= in_scalar_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (e_mode_r)
        MODE_ADD: ws[i] = WP'(e_a_r[i]) + WP'(e_b_r[i]);
        MODE_SUB: ws[i] = WP'(e_a_r[i]) - WP'(e_b_r[i]);
        default:  ws[i] = -WP'(e_a_r[i]);
      endcase
      sv_ov[i] = ws[i][WORD_W] != ws[i][WORD_W-1];
      sv[i]    = sv_ov[i] ? (ws[i][WORD_W] ? QMIN : QMAX) : ws[i][WORD_W-1:0];
      dv[i]    = (e_mode_r == MODE_DIVSCALE) ? e_s_r : e_b_r[i];
      dmag0[i] = dv[i][WORD_W-1] ? WORD_W'(-dv[i]) : WORD_W'(dv[i]);
      amag0[i] = e_a_r[i][WORD_W-1] ? WORD_W'(-e_a_r[i]) : WORD_W'(e_a_r[i]);
    end
    eq0 = (e_a_r[0] == e_b_r[0]) && (e_a_r[1] == e_b_r[1]) && (e_a_r[2] == e_b_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_a_r[0]   <= e_mode_r;
      a_a_r[0]      <= e_a_r;
      amag_a_r[0]   <= amag0;
      dmag_a_r[0]   <= dmag0;
      dneg_a_r[0]   <= {dv[2][WORD_W-1], dv[1][WORD_W-1], dv[0][WORD_W-1]};
      simp_a_r[0]   <= sv;
      simpov_a_r[0] <= |sv_ov;
      eq_a_r[0]     <= eq0;
      for (int k = 1; k < DA; k++) begin
        mode_a_r[k]   <= mode_a_r[k-1];
        a_a_r[k]      <= a_a_r[k-1];
        amag_a_r[k]   <= amag_a_r[k-1];
        dmag_a_r[k]   <= dmag_a_r[k-1];
        dneg_a_r[k]   <= dneg_a_r[k-1];
        simp_a_r[k]   <= simp_a_r[k-1];
        simpov_a_r[k] <= simpov_a_r[k-1];
        eq_a_r[k]     <= eq_a_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3a_mul_lane #(
      .WORD_W (WORD_W),
      .LANE   (l)
    ) u_mul_lane (
      .clk  (clk),
      .en   (adv),
      .mode (e_mode_r),
      .a    (e_a_r),
      .b    (e_b_r),
      .s    (e_s_r),
      .c    (lane_c[l])
    );
  end

  v3a_merge #(
    .WORD_W (WORD_W),
    .FRAC_W (FRAC_W)
  ) u_merge (
    .clk      (clk),
    .en       (adv),
    .c        (lane_c),
    .lane_res (m_lres),
    .lane_ov  (m_lov),
    .sc_res   (m_sc),
    .sc_ov    (m_scov),
    .longer   (m_lg),
    .shorter  (m_sh),
    .sumsq    (m_sumsq)
  );

  v3a_sqrt #(
    .ROOT_W (RW)
  ) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (m_sumsq),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      lres_m_r[0] <= m_lres;
      lov_m_r[0]  <= |m_lov;
      sc_m_r[0]   <= m_sc;
      scov_m_r[0] <= m_scov;
      lg_m_r[0]   <= m_lg;
      sh_m_r[0]   <= m_sh;
      for (int k = 1; k < RW; k++) begin
        lres_m_r[k] <= lres_m_r[k-1];
        lov_m_r[k]  <= lov_m_r[k-1];
        sc_m_r[k]   <= sc_m_r[k-1];
        scov_m_r[k] <= scov_m_r[k-1];
        lg_m_r[k]   <= lg_m_r[k-1];
        sh_m_r[k]   <= sh_m_r[k-1];
      end
    end
  end

  always_comb begin
    md      = mode_a_r[DA-1];
    pre_r   = '{default: '0};
    pre_so  = '0;
    pre_eq  = 1'b0;
    pre_lg  = 1'b0;
    pre_sh  = 1'b0;
    pre_ov  = 1'b0;
    use_div = 1'b0;
    unique case (md)
      MODE_ADD, MODE_SUB, MODE_NEG: begin
        pre_r  = simp_a_r[DA-1];
        pre_ov = simpov_a_r[DA-1];
      end
      MODE_MUL, MODE_SCALE, MODE_CROSS: begin
        pre_r  = lres_m_r[RW-1];
        pre_ov = lov_m_r[RW-1];
      end
      MODE_DIV, MODE_DIVSCALE: begin
        use_div = 1'b1;
      end
      MODE_NORM: begin
        if (root == '0) begin
          pre_r = a_a_r[DA-1];
        end else begin
          use_div = 1'b1;
        end
      end
      MODE_DOT, MODE_LENSQ, MODE_LEN2DSQ: begin
        pre_so = sc_m_r[RW-1];
        pre_ov = scov_m_r[RW-1];
      end
      MODE_LEN, MODE_LEN2D, MODE_DIST: begin
        pre_ov = root > RW'(QMAX);
        pre_so = pre_ov ? QMAX : root[WORD_W-1:0];
      end
      MODE_CMP: begin
        pre_eq = eq_a_r[DA-1];
        pre_lg = lg_m_r[RW-1];
        pre_sh = sh_m_r[RW-1];
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      dd_mag[i] = (md == MODE_NORM) ? root : RW'(dmag_a_r[DA-1][i]);
      dd_neg[i] = (md == MODE_NORM) ? 1'b0 : dneg_a_r[DA-1][i];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_div
    v3a_div_lane #(
      .WORD_W (WORD_W),
      .FRAC_W (FRAC_W),
      .DIV_W  (RW)
    ) u_div_lane (
      .clk   (clk),
      .en    (adv),
      .n_mag (amag_a_r[DA-1][l]),
      .n_neg (a_a_r[DA-1][l][WORD_W-1]),
      .d_mag (dd_mag[l]),
      .d_neg (dd_neg[l]),
      .res   (div_res[l]),
      .ovf   (div_ov[l]),
      .dz    (div_dz[l])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r_b_r[0]  <= pre_r;
      pre_so_b_r[0] <= pre_so;
      eq_b_r[0]     <= pre_eq;
      lg_b_r[0]     <= pre_lg;
      sh_b_r[0]     <= pre_sh;
      ov_b_r[0]     <= pre_ov;
      usediv_b_r[0] <= use_div;
      for (int k = 1; k <= NW; k++) begin
        pre_r_b_r[k]  <= pre_r_b_r[k-1];
        pre_so_b_r[k] <= pre_so_b_r[k-1];
        eq_b_r[k]     <= eq_b_r[k-1];
        lg_b_r[k]     <= lg_b_r[k-1];
        sh_b_r[k]     <= sh_b_r[k-1];
        ov_b_r[k]     <= ov_b_r[k-1];
        usediv_b_r[k] <= usediv_b_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (usediv_b_r[NW]) begin
        rx_r  <= div_res[0];
        ry_r  <= div_res[1];
        rz_r  <= div_res[2];
        so_r  <= '0;
        eq_r  <= 1'b0;
        lg_r  <= 1'b0;
        sh_r  <= 1'b0;
        ovf_r <= |div_ov;
        dz_r  <= |div_dz;
      end else begin
        rx_r  <= pre_r_b_r[NW][0];
        ry_r  <= pre_r_b_r[NW][1];
        rz_r  <= pre_r_b_r[NW][2];
        so_r  <= pre_so_b_r[NW];
        eq_r  <= eq_b_r[NW];
        lg_r  <= lg_b_r[NW];
        sh_r  <= sh_b_r[NW];
        ovf_r <= ov_b_r[NW];
        dz_r  <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rx         = rx_r;
  assign out_ry         = ry_r;
  assign out_rz         = rz_r;
  assign out_scalar_out = so_r;
  assign out_is_equal   = eq_r;
  assign out_is_longer  = lg_r;
  assign out_is_shorter = sh_r;
  assign out_overflow   = ovf_r;
  assign out_div_zero   = dz_r;

  a_cmp_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (eq_r || lg_r || sh_r) |-> !ovf_r && !dz_r)
    else $error("Comparison result carries overflow or divide-by-zero.");

  a_cmp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(lg_r && sh_r))
    else $error("Longer and shorter are both set.");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(vld_r))
    else $error("Pipeline moved while the result was stalled.");

  a_div_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> (so_r == '0) && !eq_r)
    else $error("Divide-by-zero flagged on a scalar result.");

endmodule

/* test/vector3_arith_unit_test.sv */
// Self-checking testbench for the three-component vector arithmetic unit.
module vector3_arith_unit_test;
  import v3a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic [3:0] mode;
    logic signed [31:0] ax, ay, az, bx, by, bz, s;
  } vec_op_t;

  typedef struct packed {
    logic signed [31:0] rx, ry, rz, so;
    logic eq, lg, sh, ov, dz;
  } vec_res_t;

  typedef struct {
    vec_op_t op;
    logic known;
    vec_res_t res;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [3:0] in_mode;
  logic signed [31:0] in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_in;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_rx, out_ry, out_rz, out_scalar_out;
  logic out_is_equal, out_is_longer, out_is_shorter, out_overflow, out_div_zero;

  vec_res_t pending_results[$];
  int errors = 0;
  bit quiet = 0;
  bit stimulus_done = 0;

  vector3_arith_unit dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint clip(input logic signed [127:0] v, output logic ov);
    ov = 0;
    if (v > WMAX) begin
      ov = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      ov = 1;
      return WMIN;
    end
    return longint'(v);
  endfunction

  // Shifts toward zero by the fraction width, then saturates.
  function automatic longint fix_trunc(input logic signed [127:0] v, inout logic ov);
    logic signed [127:0] m;
    logic o;
    longint r;
    m = v < 0 ? -v : v;
    m = m >>> FRAC_BITS;
    r = clip(v < 0 ? -m : m, o);
    ov |= o;
    return r;
  endfunction

  function automatic longint fix_div(input longint n, input longint d, inout logic ov,
                                     inout logic dz);
    logic signed [127:0] q;
    logic o;
    longint r;
    if (d == 0) begin
      dz = 1;
      return n > 0 ? WMAX : (n < 0 ? WMIN : 0);
    end
    q = ((n < 0 ? -128'sd1 * n : 128'sd1 * n) <<< FRAC_BITS) / (d < 0 ? -d : d);
    if ((n < 0) != (d < 0)) q = -q;
    r = clip(q, o);
    ov |= o;
    return r;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [63:0] r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] sum_squares(input longint x, input longint y,
                                                      input longint z);
    return 128'sd1 * x * x + 128'sd1 * y * y + 128'sd1 * z * z;
  endfunction

  function automatic longint clip_root(input logic [63:0] v, inout logic ov);
    if (v > WMAX) begin
      ov = 1;
      return WMAX;
    end
    return longint'(v);
  endfunction

  function automatic vec_res_t vector_result(input vec_op_t op);
    vec_res_t r;
    longint a[3], b[3], v[3], s, so;
    logic ov, dz, o;
    logic [63:0] len;
    logic signed [127:0] la, lb;
    a = '{op.ax, op.ay, op.az};
    b = '{op.bx, op.by, op.bz};
    s = op.s;
    v = '{0, 0, 0};
    so = 0;
    ov = 0;
    dz = 0;
    r = '0;
    case (mode_t'(op.mode))
      MODE_ADD: for (int i = 0; i < 3; i++) begin
        v[i] = clip(128'sd1 * a[i] + b[i], o);
        ov |= o;
      end
      MODE_SUB: for (int i = 0; i < 3; i++) begin
        v[i] = clip(128'sd1 * a[i] - b[i], o);
        ov |= o;
      end
      MODE_MUL: for (int i = 0; i < 3; i++) v[i] = fix_trunc(128'sd1 * a[i] * b[i], ov);
      MODE_DIV: for (int i = 0; i < 3; i++) v[i] = fix_div(a[i], b[i], ov, dz);
      MODE_SCALE: for (int i = 0; i < 3; i++) v[i] = fix_trunc(128'sd1 * a[i] * s, ov);
      MODE_DIVSCALE: for (int i = 0; i < 3; i++) v[i] = fix_div(a[i], s, ov, dz);
      MODE_CROSS: begin
        v[0] = fix_trunc(128'sd1 * a[1] * b[2] - 128'sd1 * a[2] * b[1], ov);
        v[1] = fix_trunc(128'sd1 * a[2] * b[0] - 128'sd1 * a[0] * b[2], ov);
        v[2] = fix_trunc(128'sd1 * a[0] * b[1] - 128'sd1 * a[1] * b[0], ov);
      end
      MODE_DOT: so = fix_trunc(128'sd1 * a[0] * b[0] + 128'sd1 * a[1] * b[1]
                               + 128'sd1 * a[2] * b[2], ov);
      MODE_LENSQ: so = fix_trunc(sum_squares(a[0], a[1], a[2]), ov);
      MODE_LEN: so = clip_root(root_floor(sum_squares(a[0], a[1], a[2])), ov);
      MODE_LEN2DSQ: so = fix_trunc(sum_squares(a[0], a[1], 0), ov);
      MODE_LEN2D: so = clip_root(root_floor(sum_squares(a[0], a[1], 0)), ov);
      MODE_NORM: begin
        len = root_floor(sum_squares(a[0], a[1], a[2]));
        for (int i = 0; i < 3; i++) v[i] = len == 0 ? a[i] : fix_div(a[i], len, ov, dz);
      end
      MODE_DIST: so = clip_root(root_floor(sum_squares(a[0] - b[0], a[1] - b[1],
                                                       a[2] - b[2])), ov);
      MODE_NEG: for (int i = 0; i < 3; i++) begin
        v[i] = clip(-128'sd1 * a[i], o);
        ov |= o;
      end
      default: begin
        la = sum_squares(a[0], a[1], a[2]);
        lb = sum_squares(b[0], b[1], b[2]);
        r.eq = a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
        r.lg = la > lb;
        r.sh = la < lb;
      end
    endcase
    r.rx = 32'(v[0]);
    r.ry = 32'(v[1]);
    r.rz = 32'(v[2]);
    r.so = 32'(so);
    r.ov = ov;
    r.dz = dz;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vec_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected transaction at %0t", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_rx !== want.rx) report_mismatch("rx", out_rx, want.rx);
        if (out_ry !== want.ry) report_mismatch("ry", out_ry, want.ry);
        if (out_rz !== want.rz) report_mismatch("rz", out_rz, want.rz);
        if (out_scalar_out !== want.so) report_mismatch("scalar_out", out_scalar_out, want.so);
        if (out_is_equal !== want.eq) report_mismatch("is_equal", out_is_equal, want.eq);
        if (out_is_longer !== want.lg) report_mismatch("is_longer", out_is_longer, want.lg);
        if (out_is_shorter !== want.sh) report_mismatch("is_shorter", out_is_shorter, want.sh);
        if (out_overflow !== want.ov) report_mismatch("overflow", out_overflow, want.ov);
        if (out_div_zero !== want.dz) report_mismatch("div_zero", out_div_zero, want.dz);
      end
    end
  end

  // The receiver stalls in random bursts until the quiet part of the run.
  initial begin
    int n;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $signed(32'($urandom_range(0, 8))) - 4;
      2: return ($urandom & 32'h0003ffff) - 32'h00020000;
      3: return 32'($urandom_range(0, 3)) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input vec_op_t op, input vec_res_t want);
    in_mode <= op.mode;
    in_ax <= op.ax;
    in_ay <= op.ay;
    in_az <= op.az;
    in_bx <= op.bx;
    in_by_comp <= op.by;
    in_bz <= op.bz;
    in_scalar_in <= op.s;
    in_valid <= 1;
    pending_results.push_back(want);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  localparam logic signed [31:0] PMAX = 32'h7fffffff;
  localparam logic signed [31:0] PMIN = 32'h80000000;
  localparam logic signed [31:0] ONE = 32'h00010000;

  table_row_t directed[$];

  task automatic add_row(input mode_t m, input logic signed [31:0] ax, ay, az, bx, by, bz, s,
                         input logic known = 0, input vec_res_t res = '0);
    table_row_t row;
    row.op = '{m, ax, ay, az, bx, by, bz, s};
    row.known = known;
    row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    vec_op_t op;
    rst_n <= 0;
    in_valid <= 0;
    in_mode <= 0;
    {in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_in} <= '0;
    add_row(MODE_ADD, PMAX, PMIN, 1, 1, -1, 2, 0, 1, '{PMAX, PMIN, 3, 0, 0, 0, 0, 1, 0});
    add_row(MODE_SUB, PMIN, PMAX, 5, 1, -1, 2, 0, 1, '{PMIN, PMAX, 3, 0, 0, 0, 0, 1, 0});
    add_row(MODE_MUL, PMAX, PMIN, ONE, PMAX, PMIN, -ONE, 0);
    add_row(MODE_DIV, ONE, -ONE, 0, 0, 0, 0, 0, 1, '{PMAX, PMIN, 0, 0, 0, 0, 0, 0, 1});
    add_row(MODE_DIV, PMAX, PMIN, 3 * ONE, 1, 1, -2 * ONE, 0);
    add_row(MODE_SCALE, PMAX, PMIN, ONE, 0, 0, 0, -ONE);
    add_row(MODE_DIVSCALE, ONE, -ONE, 0, 0, 0, 0, 0, 1, '{PMAX, PMIN, 0, 0, 0, 0, 0, 0, 1});
    add_row(MODE_DIVSCALE, PMAX, 7, PMIN, 0, 0, 0, 3);
    add_row(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 1, '{0, 0, ONE, 0, 0, 0, 0, 0, 0});
    add_row(MODE_CROSS, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, 0);
    add_row(MODE_DOT, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 0);
    add_row(MODE_LENSQ, PMAX, PMIN, PMAX, 0, 0, 0, 0);
    add_row(MODE_LEN, PMIN, PMIN, PMIN, 0, 0, 0, 0);
    add_row(MODE_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 5 * ONE, 0, 0, 0, 0, 0});
    add_row(MODE_LEN2DSQ, ONE, ONE, PMAX, 0, 0, 0, 0);
    add_row(MODE_LEN2D, PMAX, PMAX, 9, 0, 0, 0, 0);
    add_row(MODE_NORM, 0, 0, 0, 1, 2, 3, 4, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row(MODE_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    add_row(MODE_NORM, PMIN, PMAX, 1, 0, 0, 0, 0);
    add_row(MODE_DIST, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 0);
    add_row(MODE_NEG, PMIN, PMAX, 0, 0, 0, 0, 0, 1, '{PMAX, -PMAX, 0, 0, 0, 0, 0, 1, 0});
    add_row(MODE_CMP, 1, 2, 3, 1, 2, 3, 0, 1, '{0, 0, 0, 0, 1, 0, 0, 0, 0});
    add_row(MODE_CMP, 1, 2, 3, 3, 2, 1, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row(MODE_CMP, PMIN, 0, 0, PMAX, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 0, 0, 0});
    add_row(MODE_CMP, 0, 0, 0, 0, 0, -1, 0, 1, '{0, 0, 0, 0, 0, 0, 1, 0, 0});
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) begin
      send(directed[i].op, directed[i].known ? directed[i].res : vector_result(directed[i].op));
      sender_gap();
    end
    in_valid <= 0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    for (int n = 0; n < 1500; n++) begin
      op.mode = 4'($urandom_range(0, 15));
      op.ax = rand_word();
      op.ay = rand_word();
      op.az = rand_word();
      op.bx = $urandom_range(0, 7) == 0 ? op.ax : rand_word();
      op.by = $urandom_range(0, 7) == 0 ? op.ay : rand_word();
      op.bz = $urandom_range(0, 7) == 0 ? op.az : rand_word();
      op.s = rand_word();
      if (n == 1200) quiet = 1;
      send(op, vector_result(op));
      sender_gap();
    end
    in_valid <= 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* vector3_arith_unit.f */
rtl/v3a_pkg.sv
rtl/v3a_mul_lane.sv
rtl/v3a_merge.sv
rtl/v3a_sqrt.sv
rtl/v3a_div_lane.sv
rtl/vector3_arith_unit.sv
test/vector3_arith_unit_test.sv
